// ===== hw/rtl/ste_pkg.sv =====
`timescale 1ns / 1ps

package ste_pkg;

	// frequency count, clamped to the supported range
	localparam int HALF = 32;
	localparam int COUNT = (HALF < 1) ? 1 : ((HALF > 64) ? 64 : HALF);

	// field widths
	localparam int TIME_W = 16;
	localparam int IDX_W = 6;
	localparam int VAL_W = 16;

	// series steps for sine and cosine
	localparam int STEPS = 6;
	localparam int STEP_W = 3;

	// reciprocal rom geometry
	localparam int ROM_AW = (COUNT > 1) ? $clog2(COUNT) : 1;
	localparam int ROM_DEPTH = 1 << ROM_AW;
	localparam int G_DIV = (COUNT > 1) ? (COUNT - 1) : 1;

	// fixed-point constants
	localparam logic [63:0] Q30_ONE = 64'd1073741824;
	localparam logic [63:0] LN2_Q30 = 64'd744261118;
	localparam logic [63:0] LN1000_Q30 = 64'd7417145753;
	localparam logic [31:0] PI_Q30 = 32'd3373259426;

	typedef logic [31:0] recip_rom_t [ROM_DEPTH];

	// reciprocal periods in Q8.24, geometric from 250 down to 0.25
	function automatic recip_rom_t build_recip_rom();
		recip_rom_t rom;
		logic [63:0] g;
		logic [63:0] n;
		logic [63:0] y;
		logic [63:0] sum;
		logic [63:0] term;
		logic [63:0] full;
		for (int i = 0; i < ROM_DEPTH; i++) begin
			if (i < COUNT) begin
				g = (COUNT > 1) ? ((64'(i) * LN1000_Q30) / G_DIV) : 64'd0;
				n = g / LN2_Q30;
				if (n > 64'd20) begin
					n = 64'd20;
				end
				y = g - n * LN2_Q30;
				if (y >= Q30_ONE) begin
					y = Q30_ONE - 64'd1;
				end
				// exp(-y) by truncated taylor terms
				sum = Q30_ONE;
				term = Q30_ONE;
				for (int k = 1; k <= 16; k++) begin
					term = ((term * y) >> 30) / 64'(k);
					if ((k % 2) == 1) begin
						sum = sum - term;
					end else begin
						sum = sum + term;
					end
				end
				full = (64'd250 * sum + (64'd1 << (n + 64'd5))) >> (n + 64'd6);
				rom[i] = full[31:0];
			end else begin
				rom[i] = 32'd0;
			end
		end
		return rom;
	endfunction

	localparam recip_rom_t RECIP_ROM = build_recip_rom();

	// commands from the sequencer to the datapath
	typedef struct packed {
		logic load;
		logic phase;
		logic angle;
		logic square;
		logic mul;
		logic recip;
		logic corr;
		logic emit;
		logic [STEP_W-1:0] step;
		logic [IDX_W-1:0] idx;
		logic last;
	} ste_cmd_t;

endpackage

// ===== hw/rtl/ste_ctrl.sv =====
`timescale 1ns / 1ps

module ste_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output ste_pkg::ste_cmd_t cmd
);
	import ste_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PHASE,
		S_ANGLE,
		S_SQUARE,
		S_MUL,
		S_RECIP,
		S_CORR,
		S_EMIT
	} state_t;

	state_t state_q;
	logic [IDX_W-1:0] idx_q;
	logic [STEP_W-1:0] step_q;
	logic last_idx;

	assign busy = (state_q != S_IDLE);
	assign last_idx = (idx_q == IDX_W'(COUNT - 1));

	// sequencer: per frequency phase, angle, square, six series steps, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			step_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						idx_q <= '0;
						state_q <= S_PHASE;
					end
				end
				S_PHASE: begin
					state_q <= S_ANGLE;
				end
				S_ANGLE: begin
					state_q <= S_SQUARE;
				end
				S_SQUARE: begin
					step_q <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_RECIP;
				end
				S_RECIP: begin
					state_q <= S_CORR;
				end
				S_CORR: begin
					if (step_q == STEP_W'(STEPS - 1)) begin
						state_q <= S_EMIT;
					end else begin
						step_q <= step_q + 1'b1;
						state_q <= S_MUL;
					end
				end
				S_EMIT: begin
					if (last_idx) begin
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_PHASE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd = '0;
		cmd.load = (state_q == S_IDLE) && start;
		cmd.phase = (state_q == S_PHASE);
		cmd.angle = (state_q == S_ANGLE);
		cmd.square = (state_q == S_SQUARE);
		cmd.mul = (state_q == S_MUL);
		cmd.recip = (state_q == S_RECIP);
		cmd.corr = (state_q == S_CORR);
		cmd.emit = (state_q == S_EMIT);
		cmd.step = step_q;
		cmd.idx = idx_q;
		cmd.last = last_idx;
	end

	// checks
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_W'(COUNT - 1))
		else $error("frequency index past the last one");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q < STEP_W'(STEPS))
		else $error("series step out of range");

	a_start_run: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_PHASE && idx_q == '0))
		else $error("accepted transaction did not begin a run at index zero");

endmodule

// ===== hw/rtl/ste_dp.sv =====
`timescale 1ns / 1ps

module ste_dp (
	input  logic clk,
	input  logic arst_n,
	input  ste_pkg::ste_cmd_t cmd,
	input  logic [ste_pkg::TIME_W-1:0] time_req,
	output logic result_strobe,
	output logic [ste_pkg::IDX_W-1:0] index,
	output logic signed [ste_pkg::VAL_W-1:0] sine_value,
	output logic signed [ste_pkg::VAL_W-1:0] cosine_value,
	output logic last
);
	import ste_pkg::*;

	// series divisors and their truncated reciprocals in Q0.32
	localparam logic [7:0] DIV_SIN [STEPS] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};
	localparam logic [7:0] DIV_COS [STEPS] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132};
	localparam logic [63:0] TWO32 = 64'h1_0000_0000;
	localparam logic [31:0] RCP_SIN [STEPS] = '{
		32'(TWO32 / 6), 32'(TWO32 / 20), 32'(TWO32 / 42),
		32'(TWO32 / 72), 32'(TWO32 / 110), 32'(TWO32 / 156)};
	localparam logic [31:0] RCP_COS [STEPS] = '{
		32'(TWO32 / 2), 32'(TWO32 / 12), 32'(TWO32 / 30),
		32'(TWO32 / 56), 32'(TWO32 / 90), 32'(TWO32 / 132)};

	logic [TIME_W-1:0] time_q;
	logic [2:0] oct_q;
	logic [29:0] r_q;
	logic [29:0] x_q;
	logic [29:0] x2_q;
	logic [30:0] st_q, ct_q;
	logic [30:0] ss_q, cs_q;
	logic [30:0] ps_q, pc_q;
	logic [30:0] qs0_q, qc0_q;

	logic [31:0] rom_f;
	logic [47:0] phase_prod;
	logic [31:0] frac;
	logic [62:0] angle_sum;
	logic [60:0] sq_sum;
	logic [60:0] mul_s, mul_c;
	logic [62:0] rcp_s, rcp_c;
	logic [30:0] rem_s, rem_c;
	logic [30:0] qs, qc;
	logic [30:0] sv, cv;
	logic swap, sin_neg, cos_neg;

	function automatic logic [VAL_W-1:0] to_q15(input logic [30:0] v, input logic neg);
		logic [31:0] t;
		logic [16:0] q;
		logic [VAL_W-1:0] m;
		t = 32'(v) + 32'h0000_4000;
		q = t[31:15];
		m = (q > 17'd32767) ? 16'd32767 : q[15:0];
		return neg ? (16'd0 - m) : m;
	endfunction

	// phase in turns, fraction kept, octant split and mirror
	assign rom_f = RECIP_ROM[cmd.idx[ROM_AW-1:0]];
	assign phase_prod = 48'(time_q) * 48'(rom_f);
	assign frac = phase_prod[38:7];

	// octant angle in Q2.30
	assign angle_sum = 63'(r_q) * 63'(PI_Q30) + 63'(Q30_ONE);

	// angle squared
	assign sq_sum = 61'(x_q) * 61'(x_q) + 61'd536870912;

	// series term times x squared
	assign mul_s = 61'(st_q) * 61'(x2_q);
	assign mul_c = 61'(ct_q) * 61'(x2_q);

	// quotient estimate by reciprocal
	assign rcp_s = 63'(ps_q) * 63'(RCP_SIN[cmd.step]);
	assign rcp_c = 63'(pc_q) * 63'(RCP_COS[cmd.step]);

	// one-step correction of the estimate
	assign rem_s = ps_q - 31'(qs0_q * 31'(DIV_SIN[cmd.step]));
	assign rem_c = pc_q - 31'(qc0_q * 31'(DIV_COS[cmd.step]));
	assign qs = qs0_q + 31'(rem_s >= 31'(DIV_SIN[cmd.step]));
	assign qc = qc0_q + 31'(rem_c >= 31'(DIV_COS[cmd.step]));

	// octant mapping
	assign swap = oct_q[0] ^ oct_q[1];
	assign sin_neg = oct_q[2];
	assign cos_neg = oct_q[2] ^ oct_q[1];
	assign sv = swap ? cs_q : ss_q;
	assign cv = swap ? ss_q : cs_q;

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			time_q <= time_req;
		end
		if (cmd.phase) begin
			oct_q <= frac[31:29];
			r_q <= frac[29] ? (30'h2000_0000 - {1'b0, frac[28:0]}) : {1'b0, frac[28:0]};
		end
		if (cmd.angle) begin
			x_q <= angle_sum[60:31];
		end
		if (cmd.square) begin
			x2_q <= sq_sum[59:30];
			st_q <= 31'(x_q);
			ss_q <= 31'(x_q);
			ct_q <= 31'(Q30_ONE);
			cs_q <= 31'(Q30_ONE);
		end
		if (cmd.mul) begin
			ps_q <= mul_s[60:30];
			pc_q <= mul_c[60:30];
		end
		if (cmd.recip) begin
			qs0_q <= rcp_s[62:32];
			qc0_q <= rcp_c[62:32];
		end
		if (cmd.corr) begin
			st_q <= qs;
			ct_q <= qc;
			// odd terms subtract, even terms add
			if (!cmd.step[0]) begin
				ss_q <= ss_q - qs;
				cs_q <= cs_q - qc;
			end else begin
				ss_q <= ss_q + qs;
				cs_q <= cs_q + qc;
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= cmd.emit;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			index <= cmd.idx;
			last <= cmd.last;
			sine_value <= to_q15(sv, sin_neg);
			cosine_value <= to_q15(cv, cos_neg);
		end
	end

	// checks
	a_no_min_sine: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (sine_value != 16'sh8000 && cosine_value != 16'sh8000))
		else $error("result value reached the negative full scale");

	a_angle_bound: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.angle) |-> (x_q <= 30'd843314857))
		else $error("octant angle exceeds a quarter of pi");

	a_strobe_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> result_strobe)
		else $error("emit command did not raise the result strobe");

endmodule

// ===== hw/rtl/sinusoidal_time_embedding.sv =====
`timescale 1ns / 1ps

// Sinusoidal time embedding. Pulse start with a Q1.15 time on time_req while
// busy is low; the block then produces COUNT results (HALF clamped to 1..64,
// 32 by default), one per frequency index from 0 up, each carrying the Q1.15
// sine and cosine of that frequency's phase, with last set on the final one.
// Each result is shown for exactly one cycle with result_strobe high and must
// be taken then, as there is no way to hold it. Every result passes through the
// phase product, the angle scaling and the square, then the six series steps,
// each through the shared multiply, reciprocal and correction unit in turn,
// then formatting. busy drops in the cycle that the last result appears, and a
// new start may be given there.
module sinusoidal_time_embedding (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [ste_pkg::TIME_W-1:0] time_req,
	output logic result_strobe,
	output logic [ste_pkg::IDX_W-1:0] index,
	output logic signed [ste_pkg::VAL_W-1:0] sine_value,
	output logic signed [ste_pkg::VAL_W-1:0] cosine_value,
	output logic last
);
	import ste_pkg::*;

	ste_cmd_t cmd;

	// sequencer
	ste_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// arithmetic
	ste_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.time_req      (time_req),
		.result_strobe (result_strobe),
		.index         (index),
		.sine_value    (sine_value),
		.cosine_value  (cosine_value),
		.last          (last)
	);

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

	localparam int N_FREQ = (ste_pkg::HALF < 1) ? 1 :
		((ste_pkg::HALF > 64) ? 64 : ste_pkg::HALF);

	// fixed-point constants for the predictor
	localparam logic [63:0] ONE_Q30 = 64'd1073741824;
	localparam logic [63:0] LOG2_Q30 = 64'd744261118;
	localparam logic [63:0] LOG1000_Q30 = 64'd7417145753;
	localparam logic [63:0] PI_FIX_Q30 = 64'd3373259426;

	typedef struct {
		logic [ste_pkg::TIME_W-1:0] t;
		bit drain;
	} time_item_t;

	typedef struct {
		logic [ste_pkg::IDX_W-1:0] idx;
		logic [ste_pkg::VAL_W-1:0] sin_q15;
		logic [ste_pkg::VAL_W-1:0] cos_q15;
		logic last;
	} embed_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [ste_pkg::TIME_W-1:0] time_req = '0;
	logic busy;
	logic result_strobe;
	logic [ste_pkg::IDX_W-1:0] index;
	logic signed [ste_pkg::VAL_W-1:0] sine_value;
	logic signed [ste_pkg::VAL_W-1:0] cosine_value;
	logic last;

	time_item_t time_queue[$];
	embed_t pending_embeddings[$];
	logic [63:0] freq_q24 [N_FREQ];

	int errors = 0;
	int sent_count = 0;
	int total_items = 0;
	int directed_items = 0;
	int results_checked = 0;
	int drain_pauses = 0;
	int hold_off = 0;
	bit took = 1'b0;

	sinusoidal_time_embedding dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.time_req(time_req),
		.result_strobe(result_strobe),
		.index(index),
		.sine_value(sine_value),
		.cosine_value(cosine_value),
		.last(last)
	);

	always #1 clk = ~clk;

	// exp(-y) in q2.30, truncated taylor terms
	function automatic logic [63:0] exp_neg(input logic [63:0] y);
		logic [63:0] sum;
		logic [63:0] term;
		sum = ONE_Q30;
		term = ONE_Q30;
		for (int k = 1; k <= 16; k++) begin
			term = ((term * y) >> 30) / 64'(k);
			if (k % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		return sum;
	endfunction

	// reciprocal period of index i in q8.24
	function automatic logic [63:0] recip_period(input int i);
		logic [63:0] g;
		logic [63:0] n;
		logic [63:0] y;
		g = 64'd0;
		if (N_FREQ > 1) begin
			g = (64'(i) * LOG1000_Q30) / 64'(N_FREQ - 1);
		end
		n = g / LOG2_Q30;
		if (n > 64'd20) begin
			n = 64'd20;
		end
		y = g - n * LOG2_Q30;
		if (y >= ONE_Q30) begin
			y = ONE_Q30 - 64'd1;
		end
		return (64'd250 * exp_neg(y) + (64'd1 << (n + 64'd5))) >> (n + 64'd6);
	endfunction

	// sine and cosine series of a q2.30 angle in the first octant
	task automatic sin_cos(input logic [63:0] x, output logic [63:0] s, output logic [63:0] c);
		logic [63:0] x2;
		logic [63:0] st;
		logic [63:0] ct;
		x2 = (x * x + (64'd1 << 29)) >> 30;
		st = x;
		s = x;
		ct = ONE_Q30;
		c = ONE_Q30;
		for (int k = 1; k <= 6; k++) begin
			st = ((st * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
			ct = ((ct * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
			if (k % 2 == 1) begin
				s = s - st;
				c = c - ct;
			end else begin
				s = s + st;
				c = c + ct;
			end
		end
	endtask

	// round q2.30 to q1.15, saturate, apply sign
	function automatic logic [15:0] round_q15(input logic [63:0] v, input bit neg);
		logic [63:0] q;
		q = (v + (64'd1 << 14)) >> 15;
		if (q > 64'd32767) begin
			q = 64'd32767;
		end
		if (neg) begin
			q = 64'd0 - q;
		end
		return q[15:0];
	endfunction

	// expected results for one time value
	task automatic predict_embedding(input logic [ste_pkg::TIME_W-1:0] t);
		logic [63:0] frac;
		logic [63:0] oct;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] s;
		logic [63:0] c;
		embed_t e;
		for (int i = 0; i < N_FREQ; i++) begin
			frac = ((64'(t) * freq_q24[i]) >> 7) & 64'hFFFF_FFFF;
			oct = frac >> 29;
			r = frac & ((64'd1 << 29) - 64'd1);
			if (oct[0]) begin
				r = (64'd1 << 29) - r;
			end
			x = (r * PI_FIX_Q30 + (64'd1 << 30)) >> 31;
			sin_cos(x, s, c);
			e.idx = ste_pkg::IDX_W'(i);
			if (((oct + 64'd1) & 64'd2) != 0) begin
				e.sin_q15 = round_q15(c, oct[2]);
				e.cos_q15 = round_q15(s, ((oct + 64'd2) & 64'd4) != 0);
			end else begin
				e.sin_q15 = round_q15(s, oct[2]);
				e.cos_q15 = round_q15(c, ((oct + 64'd2) & 64'd4) != 0);
			end
			e.last = (i == N_FREQ - 1);
			pending_embeddings.push_back(e);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		errors++;
		$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
	endtask

	// idle length after a transaction, with a run of back-to-back items
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (sent_count % 40 < 10) begin
			return 0;
		end
		if (roll < 45) begin
			return 0;
		end else if (roll < 80) begin
			return $urandom_range(1, 8);
		end else if (roll < 93) begin
			return $urandom_range(20, 200);
		end
		return $urandom_range(400, 900);
	endfunction

	function automatic logic [15:0] random_time();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 16'($urandom_range(0, 65535));
		end else if (roll < 75) begin
			return 16'($urandom_range(0, 255));
		end else if (roll < 90) begin
			return 16'(($urandom_range(0, 31) << 11) + $urandom_range(0, 6) - 3);
		end
		return 16'($urandom_range(16'hFF00, 16'hFFFF));
	endfunction

	// monitor: check results, then predict for an accepted transaction
	always @(posedge clk) begin
		embed_t e;
		if (arst_n) begin
			if (result_strobe) begin
				if (pending_embeddings.size() == 0) begin
					report_mismatch("unexpected result, index", 32'(index), 32'hFFFF_FFFF);
				end else begin
					e = pending_embeddings.pop_front();
					results_checked++;
					if (index !== e.idx) begin
						report_mismatch("index", 32'(index), 32'(e.idx));
					end
					if (sine_value !== e.sin_q15) begin
						report_mismatch("sine_value", 32'(sine_value), 32'(e.sin_q15));
					end
					if (cosine_value !== e.cos_q15) begin
						report_mismatch("cosine_value", 32'(cosine_value), 32'(e.cos_q15));
					end
					if (last !== e.last) begin
						report_mismatch("last", 32'(last), 32'(e.last));
					end
				end
			end
			took = start && !busy;
			if (took) begin
				predict_embedding(time_req);
			end
		end
	end

	// driver: present queued time values at the falling edge
	always @(negedge clk) begin
		time_item_t item;
		if (arst_n) begin
			if (took) begin
				sent_count++;
				hold_off = pick_gap();
			end
			if (start && !took) begin
				// transaction still waiting for busy to drop
			end else if (hold_off > 0) begin
				hold_off--;
				start <= 1'b0;
				time_req <= 16'($urandom_range(0, 65535));
			end else if (time_queue.size() != 0 &&
				(!time_queue[0].drain || pending_embeddings.size() == 0)) begin
				item = time_queue.pop_front();
				if (item.drain) begin
					drain_pauses++;
				end
				start <= 1'b1;
				time_req <= item.t;
			end else begin
				start <= 1'b0;
				time_req <= 16'($urandom_range(0, 65535));
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		logic [15:0] directed [$];
		time_item_t item;
		for (int i = 0; i < N_FREQ; i++) begin
			freq_q24[i] = recip_period(i);
		end
		// extremes, exact octant boundaries of the lowest period and bit patterns
		directed = '{16'h0000, 16'h0001, 16'h0002, 16'hFFFF, 16'hFFFE, 16'h8000,
			16'h7FFF, 16'h4000, 16'h2000, 16'h0800, 16'h1000, 16'h1800, 16'h2800,
			16'h3000, 16'h3800, 16'h0801, 16'h07FF, 16'h5555, 16'hAAAA, 16'h0100};
		foreach (directed[i]) begin
			item.t = directed[i];
			item.drain = (i == 5 || i == 12);
			time_queue.push_back(item);
		end
		directed_items = directed.size();
		for (int i = 0; i < 80; i++) begin
			item.t = random_time();
			item.drain = ($urandom_range(0, 11) == 0);
			time_queue.push_back(item);
		end
		total_items = time_queue.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (sent_count < total_items || pending_embeddings.size() != 0) begin
			@(posedge clk);
		end
		repeat (64) @(posedge clk);

		$display("run covered %0d time values (%0d directed, %0d random), %0d results",
			total_items, directed_items, total_items - directed_items, results_checked);
		$display("sender drained the block %0d times, %0d mismatches", drain_pauses, errors);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// watchdog
	initial begin
		#1_500_000;
		$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/ste_pkg.sv
hw/rtl/ste_ctrl.sv
hw/rtl/ste_dp.sv
hw/rtl/sinusoidal_time_embedding.sv
verif/tb_top.sv
